FILE: hw/rtl/fcba_pkg.sv
// Package for the chain block allocator: field widths, register and command codes,
// and the width helper for the used-byte store. No dependencies.
package fcba_pkg;

	// fixed field widths
	localparam int BB_W   = 13;
	localparam int BC_W   = 9;
	localparam int REQ_W  = 21;
	localparam int BLK_W  = 8;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	// defaults and reset values
	localparam int MAX_BLOCKS_DEF      = 256;
	localparam int MAX_BLOCK_BYTES_DEF = 4096;
	localparam int BB_RESET            = 512;
	localparam int BC_RESET_CAP        = 256;

	// register select (paddr[2])
	localparam logic REG_BLOCK_BYTES = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	// command codes
	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RECYCLE = 1'b1;

	// width of a byte count: holds the saturated capacity and the reset capacity
	function automatic int ub_width(input int max_bb);
		int w;
		w = $clog2(max_bb + 1);
		if (w > BB_W) w = BB_W;
		if (w < $clog2(BB_RESET + 1)) w = $clog2(BB_RESET + 1);
		return w;
	endfunction

endpackage

FILE: hw/rtl/fcba_engine.sv
// Allocation engine: link and used-byte memories, clearing pass, scan and chain walk.
// Depends on fcba_pkg.
module fcba_engine #(
	parameter int MAX_BLOCKS      = fcba_pkg::MAX_BLOCKS_DEF,
	parameter int MAX_BLOCK_BYTES = fcba_pkg::MAX_BLOCK_BYTES_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic [fcba_pkg::ub_width(MAX_BLOCK_BYTES)-1:0]   cfg_bytes,
	input  logic [$clog2(MAX_BLOCKS+1)-1:0]                  cfg_count,
	input  logic                                             start,
	input  logic                                             cmd,
	input  logic [fcba_pkg::REQ_W-1:0]                       request_bytes,
	input  logic [fcba_pkg::BLK_W-1:0]                       start_block,
	output logic                                             busy,
	output logic                                             done,
	output logic                                             ok,
	output logic [fcba_pkg::BLK_W-1:0]                       first_block
);
	import fcba_pkg::*;

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int UB_W  = ub_width(MAX_BLOCK_BYTES);

	localparam logic [2:0] ST_CLEAR   = 3'd0;
	localparam logic [2:0] ST_IDLE    = 3'd1;
	localparam logic [2:0] ST_SCAN    = 3'd2;
	localparam logic [2:0] ST_WALK_RD = 3'd3;
	localparam logic [2:0] ST_WALK    = 3'd4;

	// memories
	logic [IDX_W-1:0] link_mem [MAX_BLOCKS];
	logic [UB_W-1:0]  used_mem [MAX_BLOCKS];

	logic             link_we, used_we;
	logic [IDX_W-1:0] link_wa, used_wa, link_ra, used_ra;
	logic [IDX_W-1:0] link_wd;
	logic [UB_W-1:0]  used_wd;
	logic [IDX_W-1:0] link_rdata_s1;
	logic [UB_W-1:0]  used_rdata_s1;

	// control and datapath registers
	logic [2:0]       state_q;
	logic [CNT_W-1:0] clr_idx_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic             vld_s1_q;
	logic [IDX_W-1:0] addr_s1;
	logic [REQ_W-1:0] remaining_q;
	logic [IDX_W-1:0] first_q, last_q;
	logic [CNT_W-1:0] taken_q;
	logic [IDX_W-1:0] walk_idx_q;
	logic [CNT_W-1:0] walk_lim_q, steps_q;
	logic             walk_fail_q;
	logic             done_q, ok_q;
	logic [IDX_W-1:0] first_out_q;

	// shared decisions
	logic             scan_hit, scan_more, scan_fin, scan_end, scan_issue;
	logic [CNT_W-1:0] steps_nx;
	logic             walk_stop, rcy_ok;

	assign scan_hit   = (state_q == ST_SCAN) && vld_s1_q && (used_rdata_s1 == '0);
	assign scan_more  = remaining_q > REQ_W'(cfg_bytes);
	assign scan_fin   = scan_hit && !scan_more;
	assign scan_end   = (state_q == ST_SCAN) && !vld_s1_q && (scan_idx_q >= cfg_count);
	assign scan_issue = (scan_idx_q < cfg_count) && !scan_fin;
	assign steps_nx   = steps_q + CNT_W'(1);
	assign walk_stop  = (link_rdata_s1 == '0) || (steps_nx == walk_lim_q);
	assign rcy_ok     = (start_block != '0) && (32'(start_block) < 32'(cfg_count));

	// memory port selection
	always_comb begin
		link_we = 1'b0;
		used_we = 1'b0;
		link_wa = walk_idx_q;
		used_wa = walk_idx_q;
		link_wd = '0;
		used_wd = '0;
		link_ra = walk_idx_q;
		used_ra = scan_idx_q[IDX_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				link_we = 1'b1;
				used_we = 1'b1;
				link_wa = clr_idx_q[IDX_W-1:0];
				used_wa = clr_idx_q[IDX_W-1:0];
			end
			ST_SCAN: begin
				if (scan_hit) begin
					used_we = 1'b1;
					used_wa = addr_s1;
					used_wd = scan_more ? cfg_bytes : UB_W'(remaining_q);
					// chain the previous block to this one
					link_we = (last_q != '0);
					link_wa = last_q;
					link_wd = addr_s1;
				end
			end
			ST_WALK: begin
				link_we = 1'b1;
				used_we = 1'b1;
				link_ra = link_rdata_s1;
			end
			default: ;
		endcase
	end

	// link memory, registered read
	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_wa] <= link_wd;
		link_rdata_s1 <= link_mem[link_ra];
	end

	// used-byte memory, registered read
	always_ff @(posedge clk) begin
		if (used_we) used_mem[used_wa] <= used_wd;
		used_rdata_s1 <= used_mem[used_ra];
	end

	// scan address pipeline (follows the read)
	always_ff @(posedge clk) begin
		addr_s1 <= scan_idx_q[IDX_W-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			scan_idx_q  <= '0;
			vld_s1_q    <= 1'b0;
			remaining_q <= '0;
			first_q     <= '0;
			last_q      <= '0;
			taken_q     <= '0;
			walk_idx_q  <= '0;
			walk_lim_q  <= '0;
			steps_q     <= '0;
			walk_fail_q <= 1'b0;
			done_q      <= 1'b0;
			ok_q        <= 1'b0;
			first_out_q <= '0;
		end else begin
			done_q   <= 1'b0;
			vld_s1_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + CNT_W'(1);
					if (clr_idx_q == CNT_W'(MAX_BLOCKS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						if (cmd == CMD_ALLOC) begin
							scan_idx_q  <= CNT_W'(1);
							remaining_q <= request_bytes;
							first_q     <= '0;
							last_q      <= '0;
							taken_q     <= '0;
							state_q     <= ST_SCAN;
						end else if (rcy_ok) begin
							walk_idx_q  <= IDX_W'(start_block);
							walk_lim_q  <= CNT_W'(MAX_BLOCKS);
							steps_q     <= '0;
							walk_fail_q <= 1'b0;
							state_q     <= ST_WALK_RD;
						end else begin
							// recycle of block zero or out of range: nothing to do
							done_q      <= 1'b1;
							ok_q        <= 1'b1;
							first_out_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						vld_s1_q   <= 1'b1;
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end
					if (scan_hit) begin
						if (first_q == '0) first_q <= addr_s1;
						if (scan_more) begin
							remaining_q <= remaining_q - REQ_W'(cfg_bytes);
							last_q      <= addr_s1;
							taken_q     <= taken_q + CNT_W'(1);
						end else begin
							done_q      <= 1'b1;
							ok_q        <= 1'b1;
							first_out_q <= (first_q == '0) ? addr_s1 : first_q;
							state_q     <= ST_IDLE;
						end
					end else if (scan_end) begin
						if (remaining_q == '0 || taken_q == '0) begin
							// zero request with no free block, or nothing taken
							done_q      <= 1'b1;
							ok_q        <= (remaining_q == '0);
							first_out_q <= '0;
							state_q     <= ST_IDLE;
						end else begin
							// out of space: unwind the partial chain
							walk_idx_q  <= first_q;
							walk_lim_q  <= taken_q;
							steps_q     <= '0;
							walk_fail_q <= 1'b1;
							state_q     <= ST_WALK_RD;
						end
					end
				end
				ST_WALK_RD: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					// current entry is cleared this cycle, next link already read
					if (walk_stop) begin
						done_q      <= 1'b1;
						ok_q        <= !walk_fail_q;
						first_out_q <= '0;
						state_q     <= ST_IDLE;
					end else begin
						walk_idx_q <= link_rdata_s1;
						steps_q    <= steps_nx;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign ok          = ok_q;
	assign first_block = BLK_W'(first_out_q);

endmodule

FILE: hw/rtl/fat_chain_block_allocator_unit.sv
// Top level of the chain block allocator: APB register file and the allocation engine.
// Depends on fcba_pkg and fcba_engine.
//
// After reset the block clears its link and used-byte memories, one entry per cycle, and
// holds busy high until clearing ends. A command is taken when start is high and busy is
// low; its single result word appears on ok and first_block for exactly one cycle with done
// high and must be captured then, since the receiver has no way to hold it. An allocate scans
// blocks from 1 upward one memory entry per cycle; a failed allocate scans on to
// block_count - 1 and then frees its partial chain at one block per cycle. A recycle walks the
// chain one link per cycle; a recycle of block zero or of a block at or beyond block_count
// answers on the next cycle. Cost per entry is set by the single read port of each memory.
// Registers block_bytes (offset 0) and block_count (offset 4) are saturated into their legal
// range when written and should change only while the block is idle.
module fat_chain_block_allocator_unit #(
	parameter int MAX_BLOCKS      = fcba_pkg::MAX_BLOCKS_DEF,
	parameter int MAX_BLOCK_BYTES = fcba_pkg::MAX_BLOCK_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fcba_pkg::ADDR_W-1:0]   paddr,
	input  logic [fcba_pkg::DATA_W-1:0]   pwdata,
	output logic [fcba_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          start,
	input  logic                          cmd,
	input  logic [fcba_pkg::REQ_W-1:0]    request_bytes,
	input  logic [fcba_pkg::BLK_W-1:0]    start_block,
	output logic                          busy,
	output logic                          done,
	output logic                          ok,
	output logic [fcba_pkg::BLK_W-1:0]    first_block
);
	import fcba_pkg::*;

	localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
	localparam int UB_W     = ub_width(MAX_BLOCK_BYTES);
	localparam int BC_RESET = (MAX_BLOCKS < BC_RESET_CAP) ? MAX_BLOCKS : BC_RESET_CAP;

	logic [UB_W-1:0]  block_bytes_q;
	logic [CNT_W-1:0] block_count_q;
	logic             cfg_wr;
	logic             reg_sel;
	logic [BB_W-1:0]  bb_raw;
	logic [BC_W-1:0]  bc_raw;
	logic [31:0]      bb_sat, bc_sat;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = paddr[ADDR_W-1];
	assign bb_raw  = pwdata[BB_W-1:0];
	assign bc_raw  = pwdata[BC_W-1:0];

	// clamp written values into range
	always_comb begin
		if (bb_raw == '0)
			bb_sat = 32'd1;
		else if (32'(bb_raw) > 32'(MAX_BLOCK_BYTES))
			bb_sat = 32'(MAX_BLOCK_BYTES);
		else
			bb_sat = 32'(bb_raw);

		if (32'(bc_raw) < 32'd2)
			bc_sat = 32'd2;
		else if (32'(bc_raw) > 32'(MAX_BLOCKS))
			bc_sat = 32'(MAX_BLOCKS);
		else
			bc_sat = 32'(bc_raw);
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= UB_W'(BB_RESET);
			block_count_q <= CNT_W'(BC_RESET);
		end else if (cfg_wr) begin
			if (reg_sel == REG_BLOCK_COUNT)
				block_count_q <= CNT_W'(bc_sat);
			else
				block_bytes_q <= UB_W'(bb_sat);
		end
	end

	// read back
	assign prdata = (reg_sel == REG_BLOCK_COUNT) ? DATA_W'(block_count_q)
	                                             : DATA_W'(block_bytes_q);

	fcba_engine #(
		.MAX_BLOCKS      (MAX_BLOCKS),
		.MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_bytes     (block_bytes_q),
		.cfg_count     (block_count_q),
		.start         (start),
		.cmd           (cmd),
		.request_bytes (request_bytes),
		.start_block   (start_block),
		.busy          (busy),
		.done          (done),
		.ok            (ok),
		.first_block   (first_block)
	);

endmodule

FILE: hw/rtl/fcba_checker.sv
// Port-level checks for the chain block allocator, bound to the top level.
// Depends on fcba_pkg and fat_chain_block_allocator_unit.
module fcba_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       cmd,
	input logic [fcba_pkg::BLK_W-1:0] start_block,
	input logic                       busy,
	input logic                       done,
	input logic                       ok,
	input logic [fcba_pkg::BLK_W-1:0] first_block
);
	import fcba_pkg::*;

	// a result word is only shown once the engine is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while busy");

	// a failed allocate reports no chain
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (first_block == '0))
		else $error("failed allocate returned a block");

	// an accepted command either starts work or answers right away
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command went nowhere");

	// recycle of block zero answers next cycle with success
	a_recycle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_RECYCLE && start_block == '0)
		|=> (done && ok && first_block == '0))
		else $error("recycle of block zero mishandled");

endmodule

bind fat_chain_block_allocator_unit fcba_checker u_fcba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.cmd         (cmd),
	.start_block (start_block),
	.busy        (busy),
	.done        (done),
	.ok          (ok),
	.first_block (first_block)
);

FILE: tb/sv/fat_chain_block_allocator_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for fat_chain_block_allocator_unit: allocate and recycle commands with random gaps,
// register settings over several phases, every result word checked against a local table copy.
// Depends on fcba_pkg and the fat_chain_block_allocator_unit RTL.
module fat_chain_block_allocator_unit_tb;
	import fcba_pkg::*;

	localparam int NBLK        = MAX_BLOCKS_DEF;
	localparam int MAXBB       = MAX_BLOCK_BYTES_DEF;
	localparam int REQ_MAX     = 1048576;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int TAIL_CYCLES = 2 * NBLK + 64;
	localparam int PHASE_ITEMS = 128;
	localparam int N_PHASES    = 9;

	typedef struct packed {
		logic              cmd;
		logic [REQ_W-1:0]  req;
		logic [BLK_W-1:0]  blk;
	} chain_cmd_t;

	typedef struct packed {
		logic              ok;
		logic [BLK_W-1:0]  first;
	} chain_reply_t;

	// DUT ports
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              start = 1'b0;
	logic              cmd = CMD_ALLOC;
	logic [REQ_W-1:0]  request_bytes = '0;
	logic [BLK_W-1:0]  start_block = '0;
	logic              busy;
	logic              done;
	logic              ok;
	logic [BLK_W-1:0]  first_block;

	// mirror of the block: configuration and both tables
	int cfg_bytes = BB_RESET;
	int cfg_count = BC_RESET_CAP;
	int next_link [NBLK];
	int fill_count [NBLK];

	chain_cmd_t   cmd_backlog[$];
	chain_reply_t replies_due[$];
	int           live_heads[$];

	int  errors = 0;
	int  cycles = 0;
	int  idle_left = 0;
	bit  quiet = 1'b0;
	int  n_alloc_ok = 0;
	int  n_alloc_fail = 0;
	int  n_recycle = 0;
	int  n_settings = 0;

	chain_cmd_t   drv_word;
	chain_reply_t drv_reply;
	bit           drv_taken;
	chain_reply_t mon_reply;

	// register settings per random phase; several are out of range and saturate
	logic [31:0] bytes_setting [N_PHASES] =
		'{512, 1, 32'h0000_1FFF, 32'hFFFF_E000, 100, 7, 32'h0001_2345, 3, 64};
	logic [31:0] count_setting [N_PHASES] =
		'{256, 2, 511, 1, 17, 64, 300, 200, 9};

	fat_chain_block_allocator_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.start         (start),
		.cmd           (cmd),
		.request_bytes (request_bytes),
		.start_block   (start_block),
		.busy          (busy),
		.done          (done),
		.ok            (ok),
		.first_block   (first_block)
	);

	always #5 clk = ~clk;

	// free and unlink a chain, at most 'steps' links
	task automatic release_chain(input int head, input int steps);
		int idx;
		int n;
		int nxt;
		idx = head;
		for (n = 0; n < steps && idx != 0 && idx < NBLK; n++) begin
			nxt = next_link[idx];
			fill_count[idx] = 0;
			next_link[idx] = 0;
			idx = nxt;
		end
	endtask

	// apply one command to the mirrored tables and return the reply word it owes
	task automatic apply_chain_cmd(input chain_cmd_t c, output chain_reply_t r);
		int remaining;
		int first;
		int last;
		int taken;
		int i;
		bit fit;
		remaining = int'(c.req);
		first = 0;
		last = 0;
		taken = 0;
		fit = 1'b0;
		r.ok = 1'b1;
		if (c.cmd == CMD_ALLOC) begin
			for (i = 1; i < cfg_count && i < NBLK && !fit; i++) begin
				if (fill_count[i] == 0) begin
					if (first == 0) first = i;
					if (last != 0) next_link[last] = i;
					taken++;
					if (remaining > cfg_bytes) begin
						remaining -= cfg_bytes;
						fill_count[i] = cfg_bytes;
						last = i;
					end else begin
						fill_count[i] = remaining;
						remaining = 0;
						fit = 1'b1;
					end
				end
			end
			if (!fit && remaining > 0) begin
				// out of space: roll back the whole partial chain
				release_chain(first, taken);
				r.ok = 1'b0;
				first = 0;
				n_alloc_fail++;
			end else begin
				n_alloc_ok++;
				if (first != 0 && c.req != 0) live_heads.push_back(first);
			end
		end else begin
			n_recycle++;
			if (int'(c.blk) != 0 && int'(c.blk) < cfg_count) release_chain(int'(c.blk), NBLK);
		end
		r.first = first[BLK_W-1:0];
	endtask

	// driver: holds start until the word is taken unless it withdraws now and then, idles in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= CMD_ALLOC;
			request_bytes <= '0;
			start_block <= '0;
			idle_left <= 0;
		end else begin
			drv_taken = start && !busy;
			if (drv_taken) begin
				drv_word = cmd_backlog.pop_front();
				apply_chain_cmd(drv_word, drv_reply);
				replies_due.push_back(drv_reply);
			end
			if (start && !drv_taken) begin
				// block still busy; now and then withdraw for a burst
				if (!quiet && $urandom_range(0, 31) == 0) begin
					start <= 1'b0;
					idle_left <= $urandom_range(0, 7);
				end
			end else if (idle_left > 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				start <= 1'b0;
				idle_left <= $urandom_range(0, 7);
			end else if (cmd_backlog.size() > 0) begin
				start <= 1'b1;
				cmd <= cmd_backlog[0].cmd;
				request_bytes <= cmd_backlog[0].req;
				start_block <= cmd_backlog[0].blk;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: each strobed word against the oldest reply due
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$error("unexpected word: ok=%0d first_block=%0d", ok, first_block);
				errors++;
			end else begin
				mon_reply = replies_due.pop_front();
				if (ok !== mon_reply.ok) begin
					$error("ok: expected %0d, got %0d", mon_reply.ok, ok);
					errors++;
				end
				if (first_block !== mon_reply.first) begin
					$error("first_block: expected %0d, got %0d", mon_reply.first, first_block);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	task automatic push_item(input logic c, input int req, input int blk);
		chain_cmd_t w;
		w.cmd = c;
		w.req = REQ_W'(req);
		w.blk = BLK_W'(blk);
		while (cmd_backlog.size() >= 2) @(posedge clk);
		cmd_backlog.push_back(w);
	endtask

	// mostly real allocations and recycles of live chains, the rest noise
	task automatic push_random_item();
		int pick;
		int sub;
		int req;
		int blk;
		int k;
		int hi;
		req = $urandom_range(0, REQ_MAX);
		blk = $urandom_range(0, 255);
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			sub = $urandom_range(0, 15);
			if (sub == 0) req = 0;
			else if (sub == 1) req = cfg_bytes * $urandom_range(1, 4);
			else if (sub < 12) req = $urandom_range(1, 3 * cfg_bytes);
			else if (sub < 14) begin
				hi = cfg_bytes * cfg_count;
				if (hi > REQ_MAX) hi = REQ_MAX;
				req = $urandom_range(1, hi);
			end
			push_item(CMD_ALLOC, req, blk);
		end else if (pick < 85 && live_heads.size() > 0) begin
			k = $urandom_range(0, live_heads.size() - 1);
			blk = live_heads[k];
			live_heads.delete(k);
			push_item(CMD_RECYCLE, req, blk);
		end else begin
			// any block: middles of chains, free blocks, out of range
			if ($urandom_range(0, 3) != 0) begin
				hi = cfg_count;
				if (hi > 255) hi = 255;
				blk = $urandom_range(0, hi);
			end
			push_item(CMD_RECYCLE, req, blk);
		end
	endtask

	// wait until nothing is queued, owed or in flight
	task automatic wait_drained();
		while (cmd_backlog.size() != 0 || start || replies_due.size() != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic int clamp_setting(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// one APB write then a readback of the same register
	task automatic write_reg(input logic sel, input logic [31:0] value);
		int sat;
		if (sel == REG_BLOCK_BYTES) sat = clamp_setting(value & 32'h1FFF, 1, MAXBB);
		else sat = clamp_setting(value & 32'h1FF, 2, NBLK);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (sel == REG_BLOCK_BYTES) cfg_bytes = sat;
		else cfg_count = sat;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== sat) begin
			$error("prdata at %0d: expected %0d, got %0d", {sel, 2'b00}, sat, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic [31:0] bytes_val, input logic [31:0] count_val);
		write_reg(REG_BLOCK_BYTES, bytes_val);
		write_reg(REG_BLOCK_COUNT, count_val);
		n_settings++;
	endtask

	// stimulus
	initial begin
		int ph;
		int n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// directed: blocks 1..4 of 16 bytes, so exhaustion is quick
		set_config(16, 5);
		push_item(CMD_ALLOC, 0, 0);            // zero request, block stays free
		push_item(CMD_ALLOC, 16, 0);           // exact fit
		push_item(CMD_ALLOC, 17, 0);           // two blocks, last nearly empty
		push_item(CMD_ALLOC, 100, 255);        // runs out, rolled back
		push_item(CMD_RECYCLE, 0, 0);          // block zero ignored
		push_item(CMD_RECYCLE, 0, 5);          // at block_count, ignored
		push_item(CMD_RECYCLE, 1048575, 255);  // beyond block_count
		push_item(CMD_RECYCLE, 0, 3);          // tail of a chain
		push_item(CMD_ALLOC, 32, 0);
		push_item(CMD_RECYCLE, 0, 2);          // predecessor still links on
		push_item(CMD_ALLOC, 48, 0);
		push_item(CMD_ALLOC, 0, 0);            // zero request with nothing free
		push_item(CMD_ALLOC, 1, 0);
		push_item(CMD_ALLOC, REQ_MAX, 0);
		push_item(CMD_RECYCLE, 0, 1);
		push_item(CMD_ALLOC, 1048575, 0);
		push_item(CMD_RECYCLE, 0, 2);
		wait_drained();

		// random phases; each ends with a full drain before the next setting
		for (ph = 0; ph < N_PHASES; ph++) begin
			set_config(bytes_setting[ph], count_setting[ph]);
			quiet = (ph == N_PHASES - 1);
			for (n = 0; n < PHASE_ITEMS; n++) push_random_item();
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (replies_due.size() != 0) begin
			$error("%0d result words never arrived", replies_due.size());
			errors++;
		end
		$display("ran %0d allocations (%0d refused) and %0d recycles", n_alloc_ok + n_alloc_fail,
			n_alloc_fail, n_recycle);
		$display("over %0d register settings, %0d errors", n_settings, errors);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: fat_chain_block_allocator_unit.f
hw/rtl/fcba_pkg.sv
hw/rtl/fcba_engine.sv
hw/rtl/fat_chain_block_allocator_unit.sv
hw/rtl/fcba_checker.sv
tb/sv/fat_chain_block_allocator_unit_tb.sv
